@@ rtl/pqpc_pkg.sv @@
// pqpc_pkg: types, constants, microcode table and arithmetic helpers of the pq power controller
package pqpc_pkg;

    // fixed-point widths
    localparam int SAMPLE_W = 16;
    localparam int WORD_W   = 32;
    localparam int GAIN_W   = 24;
    localparam int PROD_W   = GAIN_W + WORD_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W = 4;

    // default filter gains, Q.16
    localparam int FILTER_INPUT_GAIN_DEF    = 6554;
    localparam int FILTER_FEEDBACK_GAIN_DEF = -58982;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_REF        = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REACTIVE_REF      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_GAIN_ERR   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_GAIN_PERR  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_GAIN_POUT  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REACT_GAIN_ERR    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REACT_GAIN_PERR   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REACT_GAIN_POUT   = 4'd7;

    // item commands
    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_CONTROL = 1'b1;

    // input word
    typedef struct packed {
        logic                       command;
        logic signed [SAMPLE_W-1:0] volt_alpha;
        logic signed [SAMPLE_W-1:0] volt_beta;
        logic signed [SAMPLE_W-1:0] amp_alpha;
        logic signed [SAMPLE_W-1:0] amp_beta;
    } t_in_word;

    // output word
    typedef struct packed {
        logic signed [WORD_W-1:0] p_filtered;
        logic signed [WORD_W-1:0] q_filtered;
        logic signed [WORD_W-1:0] direct_current;
        logic signed [WORD_W-1:0] quadrature_current;
    } t_out_word;

    // multiplier operand a: samples, filter gains, loop gains
    typedef enum logic [3:0] {
        A_VA, A_VB, A_KIN, A_KFB,
        A_KEP, A_KPEP, A_KPOP, A_KEQ, A_KPEQ, A_KPOQ
    } t_asel;

    // multiplier operand b: samples and stored words
    typedef enum logic [3:0] {
        B_IA, B_IB, B_TMP, B_FA, B_FQ,
        B_ERRP, B_ERRQ, B_PERRP, B_PERRQ, B_PID, B_PIQ
    } t_bsel;

    // accumulator operation on the registered product
    typedef enum logic [1:0] {
        ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB
    } t_acc_op;

    // writeback of the rounded accumulator
    typedef enum logic [2:0] {
        WB_NONE, WB_TMP, WB_FA, WB_FQ, WB_ERR, WB_ID, WB_IQ
    } t_wb;

    // program layout
    localparam int PROG_LEN = 19;
    localparam int PC_W     = $clog2(PROG_LEN);
    localparam logic [PC_W-1:0] PC_MEASURE = 5'd0;
    localparam logic [PC_W-1:0] PC_CONTROL = 5'd10;

    // one control word
    typedef struct packed {
        t_asel           a;
        t_bsel           b;
        t_acc_op         acc;
        t_wb             wb;
        logic            br_ctl;
        logic [PC_W-1:0] tgt;
        logic            done;
    } t_uop;

    // microcode: the multiply of a step is accumulated one step later, and
    // writeback takes the accumulator as it stood at the start of the step
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '{a: A_VA, b: B_IA, acc: ACC_NONE, wb: WB_NONE,
              br_ctl: 1'b0, tgt: PC_MEASURE, done: 1'b0};
        case (pc)
            // measure: p and q products, then both filters
            5'd0:  begin u.a = A_VA;  u.b = B_IA; u.br_ctl = 1'b1; u.tgt = PC_CONTROL; end
            5'd1:  begin u.a = A_VB;  u.b = B_IB;  u.acc = ACC_LOAD; end
            5'd2:  begin u.a = A_VB;  u.b = B_IA;  u.acc = ACC_ADD; end
            5'd3:  begin u.a = A_VA;  u.b = B_IB;  u.acc = ACC_LOAD; u.wb = WB_TMP; end
            5'd4:  begin u.a = A_KIN; u.b = B_TMP; u.acc = ACC_SUB; end
            5'd5:  begin u.a = A_KFB; u.b = B_FA;  u.acc = ACC_LOAD; u.wb = WB_TMP; end
            5'd6:  begin u.a = A_KIN; u.b = B_TMP; u.acc = ACC_ADD; end
            5'd7:  begin u.a = A_KFB; u.b = B_FQ;  u.acc = ACC_LOAD; u.wb = WB_FA; end
            5'd8:  begin u.acc = ACC_ADD; end
            5'd9:  begin u.wb = WB_FQ; u.done = 1'b1; end
            // control: errors, then the two compensators
            5'd10: begin u.wb = WB_ERR; end
            5'd11: begin u.a = A_KEP;  u.b = B_ERRP; end
            5'd12: begin u.a = A_KPEP; u.b = B_PERRP; u.acc = ACC_LOAD; end
            5'd13: begin u.a = A_KPOP; u.b = B_PID;   u.acc = ACC_ADD; end
            5'd14: begin u.a = A_KEQ;  u.b = B_ERRQ;  u.acc = ACC_SUB; end
            5'd15: begin u.a = A_KPEQ; u.b = B_PERRQ; u.acc = ACC_LOAD; u.wb = WB_ID; end
            5'd16: begin u.a = A_KPOQ; u.b = B_PIQ;   u.acc = ACC_ADD; end
            5'd17: begin u.acc = ACC_SUB; end
            5'd18: begin u.wb = WB_IQ; u.done = 1'b1; end
            default: begin u.done = 1'b1; end
        endcase
        return u;
    endfunction

    // drop 16 fraction bits rounding half up, then saturate to 32 bits
    function automatic logic [WORD_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0]        biased;
        logic signed [ACC_W-FRAC_W-1:0] shifted;
        logic [WORD_W-1:0]              res;
        biased  = acc + ACC_W'(1 << (FRAC_W - 1));
        shifted = biased[ACC_W-1:FRAC_W];
        if (shifted[ACC_W-FRAC_W-1:WORD_W-1] == '0 ||
            shifted[ACC_W-FRAC_W-1:WORD_W-1] == '1) begin
            res = shifted[WORD_W-1:0];
        end else if (shifted[ACC_W-FRAC_W-1]) begin
            res = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    // saturated difference of two 32-bit words
    function automatic logic [WORD_W-1:0] sat_diff(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0]   d;
        logic [WORD_W-1:0] res;
        d = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        if (d[WORD_W] == d[WORD_W-1]) begin
            res = d[WORD_W-1:0];
        end else if (d[WORD_W]) begin
            res = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

@@ rtl/pq_power_controller.sv @@
// pq_power_controller: microcoded p/q power filter and current compensator
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one word per item.
// A measure word (command 0) carries alpha-beta voltage and current; the
// block forms p and q, filters both and keeps the filtered powers. A control
// word (command 1) runs the active and reactive compensators on reference
// minus filtered power and updates the direct and quadrature current commands.
// Every item gives exactly one output word (o_out_valid / i_out_stall /
// o_out_data) holding the two filtered powers and the two current commands.
// One shared 24x32 multiplier, stepped by a microcode table, does all
// products: an item occupies the sequencer for 10 steps, and no new item is
// taken until it has finished. The output register lets the next item enter
// while a result waits; if the receiver keeps stalling, the last step of
// that next item holds until the waiting word is taken. Configuration
// (i_cfg_valid / o_cfg_ready) is always ready; the user must see that it is
// written only while the block is idle, which the block itself does not
// enforce. Synchronous active-low reset clears the configuration registers,
// sequencer and controller state to zero and empties the output register.
module pq_power_controller #(
    parameter int FILTER_INPUT_GAIN    = pqpc_pkg::FILTER_INPUT_GAIN_DEF,
    parameter int FILTER_FEEDBACK_GAIN = pqpc_pkg::FILTER_FEEDBACK_GAIN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pqpc_pkg::t_in_word               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pqpc_pkg::t_out_word              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pqpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pqpc_pkg::WORD_W-1:0]      i_cfg_data
);

    localparam int W  = pqpc_pkg::WORD_W;
    localparam int GW = pqpc_pkg::GAIN_W;
    localparam int SW = pqpc_pkg::SAMPLE_W;
    localparam int PW = pqpc_pkg::PROD_W;
    localparam int AW = pqpc_pkg::ACC_W;
    localparam int FbNeg = -FILTER_FEEDBACK_GAIN;
    localparam logic signed [GW-1:0] KIN = GW'(FILTER_INPUT_GAIN);
    localparam logic signed [GW-1:0] KFB = GW'(FbNeg);

    // configuration registers
    logic [W-1:0]  r_pref, r_qref;
    logic [GW-1:0] r_kep, r_kpep, r_kpop, r_keq, r_kpeq, r_kpoq;

    // sequencer and datapath registers
    logic                     r_busy;
    logic [pqpc_pkg::PC_W-1:0] r_pc;
    pqpc_pkg::t_in_word       r_in;
    logic signed [PW-1:0]     r_prod;
    logic signed [AW-1:0]     r_acc;
    logic [W-1:0]             r_tmp;
    logic [W-1:0]             r_fa, r_fq, r_err_p, r_err_q;
    logic [W-1:0]             r_perr_p, r_perr_q, r_id, r_iq;
    logic                     r_out_valid;
    pqpc_pkg::t_out_word      r_out;

    pqpc_pkg::t_uop           uop;
    logic                     in_acc, out_acc, step_en;
    logic signed [GW-1:0]     op_a;
    logic signed [W-1:0]      op_b;
    logic signed [AW-1:0]     prod_ext;
    logic [W-1:0]             wb_val;
    logic [W-1:0]             n_fa, n_fq, n_id, n_iq;

    // handshakes
    assign o_in_stall  = r_busy;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc  = i_in_valid && !r_busy;
    assign out_acc = r_out_valid && !i_out_stall;

    // current control word; the final step waits for a free output register
    assign uop     = pqpc_pkg::uop_rom(r_pc);
    assign step_en = r_busy && !(uop.done && r_out_valid && i_out_stall);

    // operand a select
    always_comb begin
        case (uop.a)
            pqpc_pkg::A_VA:   op_a = {{(GW-SW){r_in.volt_alpha[SW-1]}}, r_in.volt_alpha};
            pqpc_pkg::A_VB:   op_a = {{(GW-SW){r_in.volt_beta[SW-1]}}, r_in.volt_beta};
            pqpc_pkg::A_KIN:  op_a = KIN;
            pqpc_pkg::A_KFB:  op_a = KFB;
            pqpc_pkg::A_KEP:  op_a = r_kep;
            pqpc_pkg::A_KPEP: op_a = r_kpep;
            pqpc_pkg::A_KPOP: op_a = r_kpop;
            pqpc_pkg::A_KEQ:  op_a = r_keq;
            pqpc_pkg::A_KPEQ: op_a = r_kpeq;
            pqpc_pkg::A_KPOQ: op_a = r_kpoq;
            default:          op_a = '0;
        endcase
    end

    // operand b select
    always_comb begin
        case (uop.b)
            pqpc_pkg::B_IA:    op_b = {{(W-SW){r_in.amp_alpha[SW-1]}}, r_in.amp_alpha};
            pqpc_pkg::B_IB:    op_b = {{(W-SW){r_in.amp_beta[SW-1]}}, r_in.amp_beta};
            pqpc_pkg::B_TMP:   op_b = r_tmp;
            pqpc_pkg::B_FA:    op_b = r_fa;
            pqpc_pkg::B_FQ:    op_b = r_fq;
            pqpc_pkg::B_ERRP:  op_b = r_err_p;
            pqpc_pkg::B_ERRQ:  op_b = r_err_q;
            pqpc_pkg::B_PERRP: op_b = r_perr_p;
            pqpc_pkg::B_PERRQ: op_b = r_perr_q;
            pqpc_pkg::B_PID:   op_b = r_id;
            pqpc_pkg::B_PIQ:   op_b = r_iq;
            default:           op_b = '0;
        endcase
    end

    // rounded, saturated accumulator and next values of the stored words
    assign prod_ext = {{(AW-PW){r_prod[PW-1]}}, r_prod};
    assign wb_val   = pqpc_pkg::rnd_sat(r_acc);
    always_comb begin
        n_fa = r_fa;
        n_fq = r_fq;
        n_id = r_id;
        n_iq = r_iq;
        case (uop.wb)
            pqpc_pkg::WB_FA: n_fa = wb_val;
            pqpc_pkg::WB_FQ: n_fq = wb_val;
            pqpc_pkg::WB_ID: n_id = wb_val;
            pqpc_pkg::WB_IQ: n_iq = wb_val;
            default: ;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pref <= '0;
            r_qref <= '0;
            r_kep  <= '0;
            r_kpep <= '0;
            r_kpop <= '0;
            r_keq  <= '0;
            r_kpeq <= '0;
            r_kpoq <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pqpc_pkg::CFG_ACTIVE_REF:       r_pref <= i_cfg_data;
                pqpc_pkg::CFG_REACTIVE_REF:     r_qref <= i_cfg_data;
                pqpc_pkg::CFG_ACTIVE_GAIN_ERR:  r_kep  <= i_cfg_data[GW-1:0];
                pqpc_pkg::CFG_ACTIVE_GAIN_PERR: r_kpep <= i_cfg_data[GW-1:0];
                pqpc_pkg::CFG_ACTIVE_GAIN_POUT: r_kpop <= i_cfg_data[GW-1:0];
                pqpc_pkg::CFG_REACT_GAIN_ERR:   r_keq  <= i_cfg_data[GW-1:0];
                pqpc_pkg::CFG_REACT_GAIN_PERR:  r_kpeq <= i_cfg_data[GW-1:0];
                pqpc_pkg::CFG_REACT_GAIN_POUT:  r_kpoq <= i_cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    // step counter with conditional jump on the item command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= pqpc_pkg::PC_MEASURE;
        end else if (in_acc) begin
            r_busy <= 1'b1;
            r_pc   <= pqpc_pkg::PC_MEASURE;
        end else if (step_en) begin
            if (uop.done) begin
                r_busy <= 1'b0;
            end else if (uop.br_ctl && r_in.command == pqpc_pkg::CMD_CONTROL) begin
                r_pc <= uop.tgt;
            end else begin
                r_pc <= r_pc + 1'b1;
            end
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    // multiplier and accumulator
    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_prod <= op_a * op_b;
            case (uop.acc)
                pqpc_pkg::ACC_LOAD: r_acc <= prod_ext;
                pqpc_pkg::ACC_ADD:  r_acc <= r_acc + prod_ext;
                pqpc_pkg::ACC_SUB:  r_acc <= r_acc - prod_ext;
                default: ;
            endcase
            if (uop.wb == pqpc_pkg::WB_TMP) begin
                r_tmp <= wb_val;
            end
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa     <= '0;
            r_fq     <= '0;
            r_err_p  <= '0;
            r_err_q  <= '0;
            r_perr_p <= '0;
            r_perr_q <= '0;
            r_id     <= '0;
            r_iq     <= '0;
        end else if (step_en) begin
            r_fa <= n_fa;
            r_fq <= n_fq;
            r_id <= n_id;
            r_iq <= n_iq;
            if (uop.wb == pqpc_pkg::WB_ERR) begin
                r_err_p <= pqpc_pkg::sat_diff(r_pref, r_fa);
                r_err_q <= pqpc_pkg::sat_diff(r_qref, r_fq);
            end
            // prior errors move once their old value has been multiplied
            if (uop.wb == pqpc_pkg::WB_ID) begin
                r_perr_p <= r_err_p;
            end
            if (uop.wb == pqpc_pkg::WB_IQ) begin
                r_perr_q <= r_err_q;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_en && uop.done) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en && uop.done) begin
            r_out.p_filtered         <= n_fa;
            r_out.q_filtered         <= n_fq;
            r_out.direct_current     <= n_id;
            r_out.quadrature_current <= n_iq;
        end
    end

    // a waiting result is never overwritten by the next item
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_out))
        else $error("output word overwritten while stalled");

    // the step counter stays inside the program while busy
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc < pqpc_pkg::PC_W'(pqpc_pkg::PROG_LEN)))
        else $error("step counter outside the program");

    // the final step of an item always presents a result
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_en && uop.done) |=> (r_out_valid && !r_busy))
        else $error("finished item gave no result");

    // stored state only moves while an item is being worked
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> ($stable(r_fa) && $stable(r_fq) && $stable(r_id) && $stable(r_iq)))
        else $error("controller state changed while idle");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for pq_power_controller, directed table then randomized phases
module tb_top;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 175;
    localparam int VEC_ROWS    = 20;
    localparam int NUM_CFG     = pqpc_pkg::CFG_REACT_GAIN_POUT + 1;
    localparam int HOLD_CYCLES = 300;
    localparam logic [pqpc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 4'd15;
    localparam pqpc_pkg::t_out_word ZERO_WORD = '0;
    // -1 * -1 / 2 = 0.5 pu = 16384, first filter pass scales by 0.1
    localparam pqpc_pkg::t_out_word HALF_P_WORD = {32'd1639, 32'd0, 32'd0, 32'd0};

    // one row of the directed table: a register write or an item
    typedef struct packed {
        logic                           is_cfg;
        logic [pqpc_pkg::CFG_IDX_W-1:0] idx;
        logic [pqpc_pkg::WORD_W-1:0]    data;
        pqpc_pkg::t_in_word             word;
        logic                           typed;
        pqpc_pkg::t_out_word            known_word;
    } t_vec_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_stall;
    pqpc_pkg::t_in_word             i_in_data;
    logic                           o_out_valid;
    logic                           i_out_stall;
    pqpc_pkg::t_out_word            o_out_data;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [pqpc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [pqpc_pkg::WORD_W-1:0]    i_cfg_data;

    // shadow of the block's registers and state
    logic [pqpc_pkg::WORD_W-1:0]        reg_shadow [NUM_CFG];
    logic signed [pqpc_pkg::WORD_W-1:0] filt_p, filt_q;
    logic signed [pqpc_pkg::WORD_W-1:0] err_p_last, id_last, err_q_last, iq_last;

    pqpc_pkg::t_out_word pending_words [$];
    pqpc_pkg::t_out_word arrived_want;
    t_vec_row            vec_table [VEC_ROWS];
    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    int unsigned         gap_pct = 0;
    int unsigned         stall_pct = 0;
    logic                hold_req = 1'b0;

    pq_power_controller DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // drop 16 fraction bits, round half up
    function automatic longint drop_frac(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [pqpc_pkg::WORD_W-1:0] clamp32(input longint v);
        if (v > longint'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
        if (v < longint'(32'sh8000_0000)) return 32'sh8000_0000;
        return v[pqpc_pkg::WORD_W-1:0];
    endfunction

    // first-order power filter with build-time gains
    function automatic logic signed [pqpc_pkg::WORD_W-1:0] filter_step(input longint x,
            input logic signed [pqpc_pkg::WORD_W-1:0] prev);
        return clamp32(drop_frac(longint'(pqpc_pkg::FILTER_INPUT_GAIN_DEF) * x
                       - longint'(pqpc_pkg::FILTER_FEEDBACK_GAIN_DEF) * longint'(prev)));
    endfunction

    // compensator, gains taken from three consecutive registers
    function automatic logic signed [pqpc_pkg::WORD_W-1:0] loop_step(input int gb,
            input logic signed [pqpc_pkg::WORD_W-1:0] err,
            input logic signed [pqpc_pkg::WORD_W-1:0] perr,
            input logic signed [pqpc_pkg::WORD_W-1:0] pout);
        longint k_e, k_pe, k_po;
        k_e  = $signed(reg_shadow[gb][pqpc_pkg::GAIN_W-1:0]);
        k_pe = $signed(reg_shadow[gb + 1][pqpc_pkg::GAIN_W-1:0]);
        k_po = $signed(reg_shadow[gb + 2][pqpc_pkg::GAIN_W-1:0]);
        return clamp32(drop_frac(k_e * longint'(err) + k_pe * longint'(perr)
                                 - k_po * longint'(pout)));
    endfunction

    // advance the shadow state by one item and form the word it gives
    function automatic pqpc_pkg::t_out_word pq_predict(input pqpc_pkg::t_in_word w);
        longint va, vb, ia, ib, p, q;
        logic signed [pqpc_pkg::WORD_W-1:0] pe, qe, id, iq;
        pqpc_pkg::t_out_word r;
        if (w.command == pqpc_pkg::CMD_MEASURE) begin
            va = w.volt_alpha;
            vb = w.volt_beta;
            ia = w.amp_alpha;
            ib = w.amp_beta;
            p = drop_frac(va * ia + vb * ib);
            q = drop_frac(vb * ia - va * ib);
            filt_p = filter_step(p, filt_p);
            filt_q = filter_step(q, filt_q);
        end else begin
            pe = clamp32(longint'($signed(reg_shadow[pqpc_pkg::CFG_ACTIVE_REF]))
                         - longint'(filt_p));
            qe = clamp32(longint'($signed(reg_shadow[pqpc_pkg::CFG_REACTIVE_REF]))
                         - longint'(filt_q));
            id = loop_step(pqpc_pkg::CFG_ACTIVE_GAIN_ERR, pe, err_p_last, id_last);
            iq = loop_step(pqpc_pkg::CFG_REACT_GAIN_ERR, qe, err_q_last, iq_last);
            err_p_last = pe;
            id_last    = id;
            err_q_last = qe;
            iq_last    = iq;
        end
        r.p_filtered         = filt_p;
        r.q_filtered         = filt_q;
        r.direct_current     = id_last;
        r.quadrature_current = iq_last;
        return r;
    endfunction

    function automatic t_vec_row item_row(input logic cmd,
            input logic [pqpc_pkg::SAMPLE_W-1:0] va,
            input logic [pqpc_pkg::SAMPLE_W-1:0] vb,
            input logic [pqpc_pkg::SAMPLE_W-1:0] ia,
            input logic [pqpc_pkg::SAMPLE_W-1:0] ib,
            input logic typed, input pqpc_pkg::t_out_word known);
        t_vec_row r;
        r = '0;
        r.word.command    = cmd;
        r.word.volt_alpha = va;
        r.word.volt_beta  = vb;
        r.word.amp_alpha  = ia;
        r.word.amp_beta   = ib;
        r.typed           = typed;
        r.known_word      = known;
        return r;
    endfunction

    function automatic t_vec_row cfg_row(input logic [pqpc_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [pqpc_pkg::WORD_W-1:0] val);
        t_vec_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = val;
        return r;
    endfunction

    // mostly short runs, a few long ones
    function automatic int run_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [pqpc_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    // offer one word, predict on acceptance
    task automatic send_item(input pqpc_pkg::t_in_word w, input logic typed,
                             input pqpc_pkg::t_out_word known);
        int gap;
        pqpc_pkg::t_out_word want;
        gap = 0;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) gap = run_length();
        repeat (gap) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = w;
        do @(posedge i_clk); while (o_in_stall);
        want = pq_predict(w);
        pending_words.push_back(typed ? known : want);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // register write; unused indexes leave the shadow alone
    task automatic write_reg(input logic [pqpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pqpc_pkg::WORD_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == pqpc_pkg::CFG_ACTIVE_REF || idx == pqpc_pkg::CFG_REACTIVE_REF) begin
            reg_shadow[idx] = val;
        end else if (idx <= pqpc_pkg::CFG_REACT_GAIN_POUT) begin
            reg_shadow[idx] = {{(pqpc_pkg::WORD_W-pqpc_pkg::GAIN_W){1'b0}},
                               val[pqpc_pkg::GAIN_W-1:0]};
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // wait until every word is back and the sequencer has gone quiet
    task automatic settle();
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // per-phase register set: full random, realistic, or extremes
    task automatic load_phase_config(input int phase);
        logic [pqpc_pkg::WORD_W-1:0] val;
        for (int r = 0; r < NUM_CFG; r++) begin
            case (phase % 3)
                0: val = $urandom();
                1: begin
                    if (r <= pqpc_pkg::CFG_REACTIVE_REF)
                        val = 32'($urandom_range(0, 65535)) - 32'd32768;
                    else
                        val = {8'($urandom()), 24'($urandom_range(0, 262143) - 131072)};
                end
                default: begin
                    if (r <= pqpc_pkg::CFG_REACTIVE_REF)
                        val = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
                    else
                        val = {8'($urandom()), $urandom_range(0, 1) ? 24'h7f_ffff : 24'h80_0000};
                end
            endcase
            write_reg(r[pqpc_pkg::CFG_IDX_W-1:0], val);
        end
        write_reg(CFG_SPARE, $urandom());
    endtask

    task automatic compare_field(input string name, input logic [pqpc_pkg::WORD_W-1:0] want,
                                 input logic [pqpc_pkg::WORD_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                mismatch_count++;
                $display("%0t: no word expected, actual %h", $time, o_out_data);
            end else begin
                arrived_want = pending_words.pop_front();
                compare_field("p_filtered", arrived_want.p_filtered,
                              o_out_data.p_filtered);
                compare_field("q_filtered", arrived_want.q_filtered,
                              o_out_data.q_filtered);
                compare_field("direct_current", arrived_want.direct_current,
                              o_out_data.direct_current);
                compare_field("quadrature_current", arrived_want.quadrature_current,
                              o_out_data.quadrature_current);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pq_power_controller: mismatch");
            $finish;
        end
    end

    // receiver stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        int stall_left;
        hold_left   = 0;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall = 1'b1;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_left  = run_length() - 1;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    // stimulus
    initial begin
        pqpc_pkg::t_in_word w;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        for (int r = 0; r < NUM_CFG; r++) reg_shadow[r] = '0;
        filt_p     = '0;
        filt_q     = '0;
        err_p_last = '0;
        id_last    = '0;
        err_q_last = '0;
        iq_last    = '0;

        // directed: reset state, sample extremes, ignored fields, then extreme registers
        vec_table[0]  = item_row(pqpc_pkg::CMD_CONTROL, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                 1'b1, ZERO_WORD);
        vec_table[1]  = item_row(pqpc_pkg::CMD_MEASURE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                 1'b1, ZERO_WORD);
        vec_table[2]  = item_row(pqpc_pkg::CMD_MEASURE, 16'h8000, 16'h0000, 16'h8000, 16'h0000,
                                 1'b1, HALF_P_WORD);
        vec_table[3]  = item_row(pqpc_pkg::CMD_MEASURE, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000,
                                 1'b0, ZERO_WORD);
        vec_table[4]  = item_row(pqpc_pkg::CMD_MEASURE, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                 1'b0, ZERO_WORD);
        vec_table[5]  = item_row(pqpc_pkg::CMD_MEASURE, 16'h7fff, 16'h0000, 16'h0000, 16'h7fff,
                                 1'b0, ZERO_WORD);
        // control word samples must be ignored
        vec_table[6]  = item_row(pqpc_pkg::CMD_CONTROL, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                 1'b0, ZERO_WORD);
        vec_table[7]  = cfg_row(pqpc_pkg::CFG_ACTIVE_REF, 32'h8000_0000);
        vec_table[8]  = cfg_row(pqpc_pkg::CFG_REACTIVE_REF, 32'h7fff_ffff);
        vec_table[9]  = cfg_row(pqpc_pkg::CFG_ACTIVE_GAIN_ERR, 32'h007f_ffff);
        vec_table[10] = cfg_row(pqpc_pkg::CFG_ACTIVE_GAIN_PERR, 32'hff80_0000);
        vec_table[11] = cfg_row(pqpc_pkg::CFG_ACTIVE_GAIN_POUT, 32'h0001_0000);
        vec_table[12] = cfg_row(pqpc_pkg::CFG_REACT_GAIN_ERR, 32'h0080_0000);
        vec_table[13] = cfg_row(pqpc_pkg::CFG_REACT_GAIN_PERR, 32'h007f_ffff);
        vec_table[14] = cfg_row(pqpc_pkg::CFG_REACT_GAIN_POUT, 32'hab7f_0000);
        // write to an unused index is dropped
        vec_table[15] = cfg_row(CFG_SPARE, 32'hffff_ffff);
        // reference minus filtered power overflows, compensator saturates
        vec_table[16] = item_row(pqpc_pkg::CMD_CONTROL, 16'h1234, 16'h8000, 16'h7fff, 16'h0001,
                                 1'b0, ZERO_WORD);
        vec_table[17] = item_row(pqpc_pkg::CMD_CONTROL, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                 1'b0, ZERO_WORD);
        vec_table[18] = item_row(pqpc_pkg::CMD_MEASURE, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                                 1'b0, ZERO_WORD);
        vec_table[19] = item_row(pqpc_pkg::CMD_CONTROL, 16'h5a5a, 16'ha5a5, 16'h0f0f, 16'hf0f0,
                                 1'b0, ZERO_WORD);

        // synchronous reset
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        gap_pct   = 20;
        stall_pct = 20;
        for (int n = 0; n < VEC_ROWS; n++) begin
            if (vec_table[n].is_cfg) begin
                settle();
                write_reg(vec_table[n].idx, vec_table[n].data);
            end else begin
                send_item(vec_table[n].word, vec_table[n].typed, vec_table[n].known_word);
            end
        end

        // random phases, each with its own register set and idling pattern
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            load_phase_config(ph);
            gap_pct   = (ph == 2) ? 0 : 25;
            stall_pct = (ph == 4) ? 0 : 25;
            // back-to-back words against a long receiver hold-off
            if (ph == 1) begin
                gap_pct  = 0;
                hold_req = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // sender pauses until the block has drained
                if (ph == 3 && k == PHASE_ITEMS / 2) settle();
                w.command    = ($urandom_range(0, 99) < 35) ? pqpc_pkg::CMD_CONTROL
                                                            : pqpc_pkg::CMD_MEASURE;
                w.volt_alpha = pick_sample();
                w.volt_beta  = pick_sample();
                w.amp_alpha  = pick_sample();
                w.amp_beta   = pick_sample();
                send_item(w, 1'b0, ZERO_WORD);
            end
        end

        // drain and finish
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("pq_power_controller: match");
        end else begin
            $display("pq_power_controller: mismatch");
        end
        $finish;
    end

endmodule
